FILE: sv/sdef_pkg.sv
// Package for the spring-damper edge force unit: widths, types and helpers.
package sdef_pkg;

  // Register indexes of the configuration port
  localparam logic [0:0] REG_SPRING_STRENGTH  = 1'b0;
  localparam logic [0:0] REG_DAMPING_FRICTION = 1'b1;

  // Reset values of the coefficients (Q16.16)
  localparam logic [30:0] SPRING_STRENGTH_RST  = 31'd65536;
  localparam logic [30:0] DAMPING_FRICTION_RST = 31'd0;

  // Pipeline shape: input, squares, sum, root bits, quotient bits, force tail
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 17;
  localparam int TAIL_STAGES = 11;
  localparam int PIPE_DEPTH = 3 + SQRT_STEPS + DIV_STEPS + TAIL_STAGES;

  // Stream widths
  localparam int IN_DATA_W  = 288;
  localparam int OUT_DATA_W = 192;

  // Per-edge operands carried along the root and divide stages
  typedef struct packed {
    logic [2:0][31:0] dmag;   // |delta_pos| per axis
    logic [2:0]       dneg;   // delta_pos sign per axis
    logic [2:0][31:0] vel;    // delta_vel per axis, two's complement
    logic [30:0]      rest;
    logic [30:0]      imf;
    logic [30:0]      ims;
    logic             degen;  // all position differences zero
  } tag_t;

  // One step of the bit-serial square root
  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] x;
    tag_t        tag;
  } sqrt_t;

  // One step of the three-lane direction divider
  typedef struct packed {
    logic [2:0][31:0] rem;
    logic [2:0][16:0] bits;
    logic [2:0][16:0] q;
    logic [31:0]      len;
    tag_t             tag;
  } div_t;

  // What the force tail still needs of an edge
  typedef struct packed {
    logic [2:0][16:0] q;      // |unit direction| per axis
    logic [2:0]       dneg;
    logic [2:0]       fneg;   // sign of force component per axis
    logic [30:0]      imf;
    logic [30:0]      ims;
    logic             degen;
  } tail_t;

  // Q32.32 product down to a Q31.16 magnitude, saturated to 2^47-1
  function automatic logic [46:0] sat47(input logic [63:0] p);
    sat47 = p[63] ? {47{1'b1}} : p[62:16];
  endfunction

  // Signed Q31.16 value from magnitude and sign
  function automatic logic signed [48:0] signed49(input logic [46:0] m, input logic neg);
    signed49 = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
  endfunction

  // Signed magnitude to saturated 32-bit two's complement
  function automatic logic [31:0] sat32(input logic [61:0] m, input logic neg);
    logic over;
    if (!neg) begin
      sat32 = (|m[61:31]) ? 32'h7FFF_FFFF : {1'b0, m[30:0]};
    end else begin
      over = (|m[61:32]) || (m[31] && (|m[30:0]));
      sat32 = over ? 32'h8000_0000 : (32'd0 - m[31:0]);
    end
  endfunction

endpackage

FILE: sv/spring_damper_edge_force_top.sv
// Top level of the spring-damper edge force unit: a fully pipelined datapath.
// Usage:
//   Each request on the s_axis channel is one spring edge: position and
//   velocity differences, rest length and both inverse masses. Each request
//   on m_axis is the matching result: acceleration increments for both end
//   nodes, with tuser set when the edge has zero length (data then zero).
//   Stiffness and damping are written on the cfg channel (index 0 and 1);
//   the user must write them only while the unit is idle, as the unit does
//   not enforce this itself; cfg_ready is always high. One edge is taken
//   per clock while the receiver does not stall. The pipeline depth is
//   set by the input stages, the 32-step square root and the 17-step
//   direction divider, one result bit per stage, plus the multiply and
//   saturate stages of the force path.
//   Synchronous reset empties the pipeline and loads stiffness 1.0 and
//   damping 0. When the receiver stalls, the whole pipeline holds and
//   s_axis_tready drops; nothing is lost or repeated.
module spring_damper_edge_force_top (
  input  logic         clk,
  input  logic         rst,
  // delta_pos_x, delta_pos_y, delta_pos_z, delta_vel_x, delta_vel_y,
  // delta_vel_z, rest_length, inv_mass_first, inv_mass_second, zero pad
  input  logic [sdef_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // accel_first_x, accel_first_y, accel_first_z,
  // accel_second_x, accel_second_y, accel_second_z
  output logic [sdef_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // degenerate
  output logic         m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  localparam int LAST = sdef_pkg::PIPE_DEPTH - 1;
  localparam int DIV_VLD = 2 + sdef_pkg::SQRT_STEPS + sdef_pkg::DIV_STEPS;

  logic                 adv;
  logic [LAST:0]        vld;
  logic [30:0]          spring_strength;
  logic [30:0]          damping_friction;

  // Coefficient registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      spring_strength  <= sdef_pkg::SPRING_STRENGTH_RST;
      damping_friction <= sdef_pkg::DAMPING_FRICTION_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sdef_pkg::REG_SPRING_STRENGTH:  spring_strength  <= cfg_data;
        sdef_pkg::REG_DAMPING_FRICTION: damping_friction <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves when the output slot is free or taken
  assign adv = ~vld[LAST] | m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], s_axis_tvalid};
    end
  end

  // Stage 0: capture, split position differences into magnitude and sign,
  // flag a zero-length edge
  sdef_pkg::tag_t s0_tag;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s0_tag.dneg[i] <= s_axis_tdata[32*i+31];
        s0_tag.dmag[i] <= s_axis_tdata[32*i+31] ? (32'd0 - s_axis_tdata[32*i +: 32])
                                                : s_axis_tdata[32*i +: 32];
        s0_tag.vel[i]  <= s_axis_tdata[96+32*i +: 32];
      end
      s0_tag.rest  <= s_axis_tdata[222:192];
      s0_tag.imf   <= s_axis_tdata[253:223];
      s0_tag.ims   <= s_axis_tdata[284:254];
      s0_tag.degen <= (s_axis_tdata[95:0] == '0);
    end
  end

  // Stage 1: squares of the position differences
  logic [2:0][63:0] s1_sq;
  sdef_pkg::tag_t   s1_tag;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_sq[i] <= 64'(s0_tag.dmag[i]) * 64'(s0_tag.dmag[i]);
      end
      s1_tag <= s0_tag;
    end
  end

  // Stage 2: sum of squares seeds the root pipeline
  sdef_pkg::sqrt_t sq [0:sdef_pkg::SQRT_STEPS];
  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0].x    <= s1_sq[0] + s1_sq[1] + s1_sq[2];
      sq[0].rem  <= '0;
      sq[0].root <= '0;
      sq[0].tag  <= s1_tag;
    end
  end

  // Square root: one result bit per stage, two radicand bits consumed
  for (genvar k = 0; k < sdef_pkg::SQRT_STEPS; k++) begin : g_sqrt
    logic [35:0] shv, tst, dif;
    logic        ge;
    assign shv = {sq[k].rem, sq[k].x[63:62]};
    assign tst = {2'b00, sq[k].root, 2'b01};
    assign dif = shv - tst;
    assign ge  = shv >= tst;
    always_ff @(posedge clk) begin
      if (adv) begin
        sq[k+1].rem  <= ge ? dif[33:0] : shv[33:0];
        sq[k+1].root <= {sq[k].root[30:0], ge};
        sq[k+1].x    <= {sq[k].x[61:0], 2'b00};
        sq[k+1].tag  <= sq[k].tag;
      end
    end
  end

  // Divider seed: (|d| << 16) / len, quotient below 2^17
  sdef_pkg::div_t dv_head;
  sdef_pkg::div_t dv [1:sdef_pkg::DIV_STEPS];
  always_comb begin
    dv_head.len = sq[sdef_pkg::SQRT_STEPS].root;
    dv_head.tag = sq[sdef_pkg::SQRT_STEPS].tag;
    for (int i = 0; i < 3; i++) begin
      dv_head.rem[i]  = {1'b0, dv_head.tag.dmag[i][31:1]};
      dv_head.bits[i] = {dv_head.tag.dmag[i][0], 16'd0};
      dv_head.q[i]    = '0;
    end
  end

  // Restoring division, three lanes, one quotient bit per stage
  for (genvar j = 0; j < sdef_pkg::DIV_STEPS; j++) begin : g_div
    sdef_pkg::div_t src;
    logic [2:0][32:0] shv, dif;
    logic [2:0]       ge;
    if (j == 0) begin : g_first
      assign src = dv_head;
    end else begin : g_rest
      assign src = dv[j];
    end
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        shv[l] = {src.rem[l], src.bits[l][16]};
        ge[l]  = shv[l] >= {1'b0, src.len};
        dif[l] = shv[l] - {1'b0, src.len};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          dv[j+1].rem[l]  <= ge[l] ? dif[l][31:0] : shv[l][31:0];
          dv[j+1].bits[l] <= {src.bits[l][15:0], 1'b0};
          dv[j+1].q[l]    <= {src.q[l][15:0], ge[l]};
        end
        dv[j+1].len <= src.len;
        dv[j+1].tag <= src.tag;
      end
    end
  end

  sdef_pkg::div_t dvo;
  assign dvo = dv[sdef_pkg::DIV_STEPS];

  // Projection products u_i * v_i
  logic signed [17:0] uq [0:2];
  logic signed [49:0] pd_prod [0:2];
  logic [31:0]        pd_len;
  logic [30:0]        pd_rest;
  sdef_pkg::tail_t    pd_tl;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      uq[l] = dvo.tag.dneg[l] ? -$signed({1'b0, dvo.q[l]}) : $signed({1'b0, dvo.q[l]});
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        pd_prod[l] <= 50'(uq[l]) * 50'($signed(dvo.tag.vel[l]));
      end
      pd_len        <= dvo.len;
      pd_rest       <= dvo.tag.rest;
      pd_tl.q       <= dvo.q;
      pd_tl.dneg    <= dvo.tag.dneg;
      pd_tl.fneg    <= '0;
      pd_tl.imf     <= dvo.tag.imf;
      pd_tl.ims     <= dvo.tag.ims;
      pd_tl.degen   <= dvo.tag.degen;
    end
  end

  // Dot product sum and stretch
  logic signed [51:0] sm_dot;
  logic signed [33:0] sm_str;
  sdef_pkg::tail_t    sm_tl;
  always_ff @(posedge clk) begin
    if (adv) begin
      sm_dot <= 52'(pd_prod[0]) + 52'(pd_prod[1]) + 52'(pd_prod[2]);
      sm_str <= $signed({2'b00, pd_len}) - $signed({3'b000, pd_rest});
      sm_tl  <= pd_tl;
    end
  end

  // Projection truncated toward zero; spring product
  logic [51:0]     dabs;
  logic [32:0]     sabs;
  logic [32:0]     pj_pmag;
  logic            pj_pneg;
  logic [63:0]     pj_sprod;
  logic            pj_sneg;
  sdef_pkg::tail_t pj_tl;
  assign dabs = sm_dot[51] ? 52'(-sm_dot) : 52'(sm_dot);
  assign sabs = sm_str[33] ? 33'(-sm_str) : 33'(sm_str);
  always_ff @(posedge clk) begin
    if (adv) begin
      pj_pmag  <= dabs[48:16];
      pj_pneg  <= sm_dot[51];
      pj_sprod <= 64'(spring_strength) * 64'(sabs);
      pj_sneg  <= sm_str[33];
      pj_tl    <= sm_tl;
    end
  end

  // Damping product; spring term saturated
  logic [63:0]        dp_dprod;
  logic               dp_dneg;
  logic signed [48:0] dp_fs;
  sdef_pkg::tail_t    dp_tl;
  always_ff @(posedge clk) begin
    if (adv) begin
      dp_dprod <= 64'(damping_friction) * 64'(pj_pmag);
      dp_dneg  <= pj_pneg;
      dp_fs    <= sdef_pkg::signed49(sdef_pkg::sat47(pj_sprod), pj_sneg);
      dp_tl    <= pj_tl;
    end
  end

  // Damping term saturated
  logic signed [48:0] ds_fs, ds_fd;
  sdef_pkg::tail_t    ds_tl;
  always_ff @(posedge clk) begin
    if (adv) begin
      ds_fs <= dp_fs;
      ds_fd <= sdef_pkg::signed49(sdef_pkg::sat47(dp_dprod), dp_dneg);
      ds_tl <= dp_tl;
    end
  end

  // Edge force F = -(spring + damping), clamped to 2^47-1
  logic signed [49:0] fsum;
  logic [49:0]        fabs;
  logic [46:0]        fo_fmag;
  logic               fo_fneg;
  sdef_pkg::tail_t    fo_tl;
  assign fsum = -(50'(ds_fs) + 50'(ds_fd));
  assign fabs = fsum[49] ? 50'(-fsum) : 50'(fsum);
  always_ff @(posedge clk) begin
    if (adv) begin
      fo_fmag <= (|fabs[49:47]) ? {47{1'b1}} : fabs[46:0];
      fo_fneg <= fsum[49];
      fo_tl   <= ds_tl;
    end
  end

  // Force components |F| * |u_i|
  logic [2:0][63:0] fp_prod;
  sdef_pkg::tail_t  fp_tl;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        fp_prod[l] <= 64'(fo_fmag) * 64'(fo_tl.q[l]);
      end
      fp_tl.q     <= fo_tl.q;
      fp_tl.dneg  <= fo_tl.dneg;
      fp_tl.fneg  <= {3{fo_fneg}} ^ fo_tl.dneg;
      fp_tl.imf   <= fo_tl.imf;
      fp_tl.ims   <= fo_tl.ims;
      fp_tl.degen <= fo_tl.degen;
    end
  end

  // Force components saturated
  logic [2:0][46:0] fs_mag;
  sdef_pkg::tail_t  fs_tl;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        fs_mag[l] <= sdef_pkg::sat47(fp_prod[l]);
      end
      fs_tl <= fp_tl;
    end
  end

  // Inverse mass products, split into high and low partial products
  logic [2:0][53:0] ip_hf, ip_hs;
  logic [2:0][54:0] ip_lf, ip_ls;
  sdef_pkg::tail_t  ip_tl;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        ip_hf[l] <= 54'(fs_mag[l][46:24]) * 54'(fs_tl.imf);
        ip_lf[l] <= 55'(fs_mag[l][23:0]) * 55'(fs_tl.imf);
        ip_hs[l] <= 54'(fs_mag[l][46:24]) * 54'(fs_tl.ims);
        ip_ls[l] <= 55'(fs_mag[l][23:0]) * 55'(fs_tl.ims);
      end
      ip_tl <= fs_tl;
    end
  end

  // Partial products combined and shifted to Q16.16
  logic [2:0][77:0] cf, cs;
  logic [2:0][61:0] im_mf, im_ms;
  sdef_pkg::tail_t  im_tl;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cf[l] = {ip_hf[l], 24'd0} + 78'(ip_lf[l]);
      cs[l] = {ip_hs[l], 24'd0} + 78'(ip_ls[l]);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        im_mf[l] <= cf[l][77:16];
        im_ms[l] <= cs[l][77:16];
      end
      im_tl <= ip_tl;
    end
  end

  // Output register: saturate to 32 bits, zero on a degenerate edge
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        m_axis_tdata[32*l +: 32]    <= im_tl.degen ? 32'd0
                                       : sdef_pkg::sat32(im_mf[l], im_tl.fneg[l]);
        m_axis_tdata[96+32*l +: 32] <= im_tl.degen ? 32'd0
                                       : sdef_pkg::sat32(im_ms[l], ~im_tl.fneg[l]);
      end
      m_axis_tuser <= im_tl.degen;
    end
  end

  assign m_axis_tvalid = vld[LAST];

  // A degenerate edge delivers all-zero accelerations
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate edge with nonzero data");

  // A held result blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // X-lane divider remainder stays below the length on a real edge
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_VLD] && !dvo.tag.degen |-> dvo.rem[0] < dvo.len)
    else $error("divider remainder out of range");

endmodule
